@@ rtl/tpfh_pkg.sv @@
// Shared types, codes and field widths of the two-level page fault handler.
`default_nettype none

package tpfh_pkg;

   // Field widths of the request and response beats.
   localparam int FAULT_TYPE_W = 2;
   localparam int ADDR_W       = 32;
   localparam int FRAME_W      = 20;
   localparam int STATUS_W     = 2;

   // Packed bus widths (padded to whole bytes).
   localparam int REQ_TDATA_W  = 56;
   localparam int RSP_TDATA_W  = 72;

   // Configuration port.
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 32;

   // Virtual address split: directory index in bits 31..21, table index in 20..12.
   localparam int DIR_SHIFT    = 21;
   localparam int PAGE_SHIFT   = 12;
   localparam int DIR_SRC_W    = ADDR_W - DIR_SHIFT;
   localparam int PAGE_SRC_W   = DIR_SHIFT - PAGE_SHIFT;

   // Low half of the TLB entry: dirty and valid always set.
   localparam logic [PAGE_SHIFT-1:0] LO_FLAGS = 12'h600;

   // Fault kinds carried in the request tuser.
   localparam logic [FAULT_TYPE_W-1:0] FAULT_READ      = 2'd0;
   localparam logic [FAULT_TYPE_W-1:0] FAULT_WRITE     = 2'd1;
   localparam logic [FAULT_TYPE_W-1:0] FAULT_READ_ONLY = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_START_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_SIZE_0  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_START_1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_SIZE_1  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_START_2 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_SIZE_2  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_START_3 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_SIZE_3  = 3'd7;

   localparam logic [CSR_INDEX_W-1:0] CSR_START_IDX [4] = '{
      CSR_REGION_START_0, CSR_REGION_START_1, CSR_REGION_START_2, CSR_REGION_START_3
   };
   localparam logic [CSR_INDEX_W-1:0] CSR_SIZE_IDX [4] = '{
      CSR_REGION_SIZE_0, CSR_REGION_SIZE_1, CSR_REGION_SIZE_2, CSR_REGION_SIZE_3
   };

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_FAULT   = 2'd1,
      STATUS_INVALID = 2'd2,
      STATUS_NOMEM   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_INDEX,
      S_DIR_READ,
      S_DIR_EVAL,
      S_PTE_EVAL,
      S_RESULT
   } state_type;

endpackage

`default_nettype wire

@@ rtl/tpfh_ram.sv @@
// Single-port-write, single-port-read memory with a registered read.
`default_nettype none

module tpfh_ram #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 5
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/tpfh_mod.sv @@
// Two-stage remainder of a narrow index by a constant table size.
`default_nettype none

module tpfh_mod #(
   parameter int IN_W    = 11,
   parameter int DIVISOR = 2048,
   parameter int OUT_W   = 11
) (
   input  wire logic             clock,
   input  wire logic [IN_W-1:0]  x,
   output logic      [OUT_W-1:0] r
);

   logic [IN_W-1:0]  x_d_ff;
   logic [OUT_W-1:0] r_ff;

   always_ff @(posedge clock) begin
      x_d_ff <= x;
   end

   generate
      if (DIVISOR >= (1 << IN_W)) begin : g_pass
         // The divisor exceeds every input value, so the remainder is the input.
         always_ff @(posedge clock) begin
            r_ff <= OUT_W'(x_d_ff);
         end
      end else begin : g_div
         // Quotient by a truncated reciprocal; it may be one low, so the
         // remainder needs at most one corrective subtraction.
         localparam int SHIFT = IN_W + 2;
         localparam logic [SHIFT-1:0] RECIP = SHIFT'((1 << SHIFT) / DIVISOR);

         logic [IN_W+SHIFT-1:0] prod;
         logic [IN_W-1:0]       q_ff;
         logic [IN_W-1:0]       qd;
         logic [IN_W-1:0]       rem;
         logic [IN_W-1:0]       rem_fix;

         assign prod = (IN_W+SHIFT)'(x) * (IN_W+SHIFT)'(RECIP);

         always_ff @(posedge clock) begin
            q_ff <= prod[IN_W+SHIFT-1:SHIFT];
         end

         assign qd      = q_ff * IN_W'(DIVISOR);
         assign rem     = x_d_ff - qd;
         assign rem_fix = (rem >= IN_W'(DIVISOR)) ? rem - IN_W'(DIVISOR) : rem;

         always_ff @(posedge clock) begin
            r_ff <= OUT_W'(rem_fix);
         end
      end
   endgenerate

   assign r = r_ff;

endmodule

`default_nettype wire

@@ rtl/tpfh_region.sv @@
// Region registers and the test of a fault address against every region.
`default_nettype none

module tpfh_region #(
   parameter int REGION_COUNT = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wen,
   input  wire logic [tpfh_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tpfh_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic [tpfh_pkg::ADDR_W-1:0]       addr,
   output logic                                   hit
);

   import tpfh_pkg::*;

   logic [ADDR_W-1:0]       start_ff [REGION_COUNT];
   logic [ADDR_W-1:0]       size_ff  [REGION_COUNT];
   logic [REGION_COUNT-1:0] in_region;

   always_ff @(posedge clock) begin
      for (int k = 0; k < REGION_COUNT; k++) begin
         if (reset) begin
            start_ff[k] <= '0;
            size_ff[k]  <= '0;
         end else if (csr_wen) begin
            if (csr_index == CSR_START_IDX[k]) start_ff[k] <= csr_wdata;
            if (csr_index == CSR_SIZE_IDX[k])  size_ff[k]  <= csr_wdata;
         end
      end
   end

   // The offset is taken one bit wider so that a region may end at the top
   // of the address space; a borrow means the address lies below the start.
   always_comb begin
      logic [ADDR_W:0] diff;
      for (int k = 0; k < REGION_COUNT; k++) begin
         diff         = {1'b0, addr} - {1'b0, start_ff[k]};
         in_region[k] = !diff[ADDR_W] && (diff[ADDR_W-1:0] < size_ff[k]);
      end
   end

   assign hit = |in_region;

endmodule

`default_nettype wire

@@ rtl/two_level_page_fault_handler.sv @@
// Top level of the two-level page table fault handler.
//
// Each request beat describes one TLB miss: req_tuser carries the fault kind,
// req_tdata the faulting virtual address and a free frame offered by the
// frame allocator. Each request yields exactly one response beat with a
// status in rsp_tuser and, on success, a TLB entry pair in rsp_tdata.
// Region registers are written through the csr_ port, by the user only while
// no request is being worked on; the block itself does not enforce this.
// The handler works on one request at a time. A rejected fault kind or an
// address outside every region is decided in the check state, after which
// the handler returns to idle for the next request. Allocating a new
// second-level table is decided in the directory evaluation state, after
// the index and directory read states; a lookup that reads a page entry is
// decided in the page entry evaluation state that follows. These paths wait
// on the index remainder unit and the dependent reads of the directory
// memory and then the page entry memory. After reset the handler sweeps
// every address of both memories to clear them, and req_tready stays low
// during the sweep. A stalled receiver holds the response in the output
// register; the handler still accepts one more request and finishes it, then
// waits with that result until the output register frees.
`default_nettype none

module two_level_page_fault_handler #(
   parameter int DIRECTORY_ENTRIES = 2048,
   parameter int TABLE_ENTRIES     = 512,
   parameter int TABLE_SLOTS       = 16,
   parameter int REGION_COUNT      = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request beat.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // tdata: fault_address [31:0], free_frame [51:32], zeros above
   input  wire logic [tpfh_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // tuser: fault_type [1:0]
   input  wire logic [tpfh_pkg::FAULT_TYPE_W-1:0] req_tuser,
   // Response beat.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // tdata: tlb_write [0], tlb_entry_hi [32:1], tlb_entry_lo [64:33],
   //        frame_taken [65], zeros above
   output logic      [tpfh_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // tuser: status [1:0]
   output logic      [tpfh_pkg::STATUS_W-1:0]     rsp_tuser,
   // Configuration writes.
   input  wire logic                              csr_wen,
   input  wire logic [tpfh_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [tpfh_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import tpfh_pkg::*;

   // Directory entries hold a slot number plus one, zero meaning empty.
   localparam int DIR_AW    = $clog2(DIRECTORY_ENTRIES);
   localparam int DIR_W     = $clog2(TABLE_SLOTS + 1);
   localparam int PG_AW     = $clog2(TABLE_ENTRIES);
   localparam int PTE_DEPTH = TABLE_SLOTS * TABLE_ENTRIES;
   localparam int PTE_AW    = $clog2(PTE_DEPTH);
   localparam int PTE_W     = FRAME_W + 1;
   localparam int CLEAR_LEN = (DIRECTORY_ENTRIES > PTE_DEPTH) ? DIRECTORY_ENTRIES : PTE_DEPTH;
   localparam int CLR_W     = $clog2(CLEAR_LEN);
   localparam int PAD_W     = RSP_TDATA_W - (2 * ADDR_W + 2);

   state_type                state_ff, state_in;
   logic [CLR_W-1:0]         clear_cnt_ff, clear_cnt_in;
   logic [DIR_W-1:0]         next_slot_ff, next_slot_in;
   logic [PTE_AW-1:0]        pte_addr_ff, pte_addr_in;

   // Captured request.
   logic [FAULT_TYPE_W-1:0]  type_ff;
   logic [ADDR_W-1:0]        addr_ff;
   logic [FRAME_W-1:0]       frame_ff;

   // Result waiting for the output register.
   status_type               res_status_ff, res_status_in;
   logic [FRAME_W-1:0]       res_frame_ff, res_frame_in;
   logic                     res_taken_ff, res_taken_in;

   // Output register.
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0]   rsp_tdata_ff, rsp_tdata_in;
   logic [STATUS_W-1:0]      rsp_tuser_ff, rsp_tuser_in;

   logic                     region_hit;
   logic [DIR_AW-1:0]        dir_idx;
   logic [PG_AW-1:0]         pg_idx;

   logic                     dir_we;
   logic [DIR_AW-1:0]        dir_wr_addr;
   logic [DIR_W-1:0]         dir_wr_data;
   logic [DIR_W-1:0]         dir_rd_data;
   logic                     pte_we;
   logic [PTE_AW-1:0]        pte_wr_addr;
   logic [PTE_W-1:0]         pte_wr_data;
   logic [PTE_W-1:0]         pte_rd_data;

   logic [DIR_W-1:0]         slot_sel;
   logic [PTE_AW-1:0]        pte_addr_calc;

   logic                     fin;
   status_type               fin_status;
   logic [FRAME_W-1:0]       fin_frame;
   logic                     fin_taken;
   logic                     out_free;
   logic [ADDR_W-1:0]        entry_hi;
   logic [ADDR_W-1:0]        entry_lo;

   tpfh_region #(
      .REGION_COUNT (REGION_COUNT)
   ) u_region (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .addr      (addr_ff),
      .hit       (region_hit)
   );

   tpfh_mod #(
      .IN_W    (DIR_SRC_W),
      .DIVISOR (DIRECTORY_ENTRIES),
      .OUT_W   (DIR_AW)
   ) u_dir_mod (
      .clock (clock),
      .x     (addr_ff[ADDR_W-1:DIR_SHIFT]),
      .r     (dir_idx)
   );

   tpfh_mod #(
      .IN_W    (PAGE_SRC_W),
      .DIVISOR (TABLE_ENTRIES),
      .OUT_W   (PG_AW)
   ) u_pg_mod (
      .clock (clock),
      .x     (addr_ff[DIR_SHIFT-1:PAGE_SHIFT]),
      .r     (pg_idx)
   );

   tpfh_ram #(
      .DEPTH (DIRECTORY_ENTRIES),
      .WIDTH (DIR_W)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (dir_wr_addr),
      .wr_data (dir_wr_data),
      .rd_addr (dir_idx),
      .rd_data (dir_rd_data)
   );

   tpfh_ram #(
      .DEPTH (PTE_DEPTH),
      .WIDTH (PTE_W)
   ) u_pte_ram (
      .clock   (clock),
      .wr_en   (pte_we),
      .wr_addr (pte_wr_addr),
      .wr_data (pte_wr_data),
      .rd_addr (pte_addr_calc),
      .rd_data (pte_rd_data)
   );

   // Slot of the second-level table: the one the directory names, or the
   // next free one when the directory entry is still empty.
   assign slot_sel      = (dir_rd_data != '0) ? dir_rd_data - DIR_W'(1) : next_slot_ff;
   assign pte_addr_calc = PTE_AW'(slot_sel) * PTE_AW'(TABLE_ENTRIES) + PTE_AW'(pg_idx);

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign entry_hi = {addr_ff[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};
   assign entry_lo = {fin_frame, LO_FLAGS};

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         type_ff  <= req_tuser;
         addr_ff  <= req_tdata[ADDR_W-1:0];
         frame_ff <= req_tdata[ADDR_W+FRAME_W-1:ADDR_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clear_cnt_ff  <= '0;
         next_slot_ff  <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_cnt_ff  <= clear_cnt_in;
         next_slot_ff  <= next_slot_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      pte_addr_ff   <= pte_addr_in;
      res_status_ff <= res_status_in;
      res_frame_ff  <= res_frame_in;
      res_taken_ff  <= res_taken_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      rsp_tuser_ff  <= rsp_tuser_in;
   end

   always_comb begin
      state_in      = state_ff;
      clear_cnt_in  = clear_cnt_ff;
      next_slot_in  = next_slot_ff;
      pte_addr_in   = pte_addr_ff;
      res_status_in = res_status_ff;
      res_frame_in  = res_frame_ff;
      res_taken_in  = res_taken_ff;
      req_tready    = 1'b0;

      dir_we        = 1'b0;
      dir_wr_addr   = dir_idx;
      dir_wr_data   = next_slot_ff + DIR_W'(1);
      pte_we        = 1'b0;
      pte_wr_addr   = pte_addr_ff;
      pte_wr_data   = {1'b1, frame_ff};

      fin           = 1'b0;
      fin_status    = res_status_ff;
      fin_frame     = res_frame_ff;
      fin_taken     = res_taken_ff;

      case (state_ff)
         S_CLEAR: begin
            dir_we       = ({1'b0, clear_cnt_ff} < (CLR_W+1)'(DIRECTORY_ENTRIES));
            dir_wr_addr  = clear_cnt_ff[DIR_AW-1:0];
            dir_wr_data  = '0;
            pte_we       = ({1'b0, clear_cnt_ff} < (CLR_W+1)'(PTE_DEPTH));
            pte_wr_addr  = clear_cnt_ff[PTE_AW-1:0];
            pte_wr_data  = '0;
            clear_cnt_in = clear_cnt_ff + CLR_W'(1);
            if (clear_cnt_ff == CLR_W'(CLEAR_LEN - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (type_ff == FAULT_READ_ONLY) begin
               fin        = 1'b1;
               fin_status = STATUS_FAULT;
               fin_frame  = '0;
               fin_taken  = 1'b0;
            end else if (type_ff != FAULT_READ && type_ff != FAULT_WRITE) begin
               fin        = 1'b1;
               fin_status = STATUS_INVALID;
               fin_frame  = '0;
               fin_taken  = 1'b0;
            end else if (!region_hit) begin
               fin        = 1'b1;
               fin_status = STATUS_FAULT;
               fin_frame  = '0;
               fin_taken  = 1'b0;
            end else begin
               state_in = S_INDEX;
            end
         end
         S_INDEX: begin
            // Remainder unit finishes the directory and table indexes.
            state_in = S_DIR_READ;
         end
         S_DIR_READ: begin
            // Directory read is under way at dir_idx.
            state_in = S_DIR_EVAL;
         end
         S_DIR_EVAL: begin
            pte_addr_in = pte_addr_calc;
            if (dir_rd_data != '0) begin
               state_in = S_PTE_EVAL;
            end else if (next_slot_ff == DIR_W'(TABLE_SLOTS)) begin
               fin        = 1'b1;
               fin_status = STATUS_NOMEM;
               fin_frame  = '0;
               fin_taken  = 1'b0;
            end else begin
               // Take a fresh table; its entries are still clear from reset,
               // so only the faulting entry needs writing.
               dir_we       = 1'b1;
               next_slot_in = next_slot_ff + DIR_W'(1);
               pte_we       = 1'b1;
               pte_wr_addr  = pte_addr_calc;
               fin          = 1'b1;
               fin_status   = STATUS_OK;
               fin_frame    = frame_ff;
               fin_taken    = 1'b1;
            end
         end
         S_PTE_EVAL: begin
            fin        = 1'b1;
            fin_status = STATUS_OK;
            if (pte_rd_data[FRAME_W]) begin
               fin_frame = pte_rd_data[FRAME_W-1:0];
               fin_taken = 1'b0;
            end else begin
               pte_we    = 1'b1;
               fin_frame = frame_ff;
               fin_taken = 1'b1;
            end
         end
         S_RESULT: begin
            fin = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tuser_in  = rsp_tuser_ff;

      if (fin) begin
         if (out_free) begin
            rsp_tvalid_in = 1'b1;
            rsp_tuser_in  = fin_status;
            if (fin_status == STATUS_OK) begin
               rsp_tdata_in = {{PAD_W{1'b0}}, fin_taken, entry_lo, entry_hi, 1'b1};
            end else begin
               rsp_tdata_in = '0;
            end
            state_in = S_IDLE;
         end else begin
            res_status_in = fin_status;
            res_frame_in  = fin_frame;
            res_taken_in  = fin_taken;
            state_in      = S_RESULT;
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire

@@ rtl/tpfh_checker.sv @@
// Port-level checks of the page fault handler and their binding.
`default_nettype none

module tpfh_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [tpfh_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input wire logic [tpfh_pkg::STATUS_W-1:0]     rsp_tuser
);

   import tpfh_pkg::*;

   // A response held by the receiver does not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Any error carries no TLB entry and consumes no frame.
   a_err_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata == '0)
      else $error("error response carries a payload");

   // A success writes the TLB with a page-aligned high half and dirty, valid low half.
   a_ok_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_OK |->
         rsp_tdata[0] && rsp_tdata[12:1] == '0 && rsp_tdata[44:33] == LO_FLAGS)
      else $error("malformed TLB entry pair");

   // Coming out of reset the block neither offers a response nor takes a request.
   a_reset_quiet: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

endmodule

bind two_level_page_fault_handler tpfh_checker u_tpfh_checker (.*);

`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the two-level page fault handler.
`default_nettype none

module tb;
   import tpfh_pkg::*;

   // Block configuration, kept at the default sizes of the handler.
   localparam int DIRECTORY_ENTRIES = 2048;
   localparam int TABLE_ENTRIES     = 512;
   localparam int TABLE_SLOTS       = 16;
   localparam int REGION_COUNT      = 4;

   // The package names only the accepted and rejected fault kinds; the
   // remaining code is an unknown kind that must be refused as invalid.
   localparam logic [FAULT_TYPE_W-1:0] FAULT_OTHER = 2'd3;

   // Ways of programming the region registers for a random phase.
   localparam int REGIONS_HOT   = 0;
   localparam int REGIONS_MIXED = 1;

   // The cycle limit leaves room for the clearing sweep and for the rest of
   // the run even with every gap and stall at its longest.
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOT_DIRS    = 12;
   localparam int HOT_PAGES   = 8;

   typedef struct packed {
      logic [FAULT_TYPE_W-1:0] kind;
      logic [ADDR_W-1:0]       addr;
      logic [FRAME_W-1:0]      frame;
   } fault_beat_type;

   typedef struct packed {
      status_type        status;
      logic              tlb_write;
      logic [ADDR_W-1:0] entry_hi;
      logic [ADDR_W-1:0] entry_lo;
      logic              frame_taken;
   } tlb_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;
   logic [FAULT_TYPE_W-1:0] req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [STATUS_W-1:0]     rsp_tuser;
   logic                    csr_wen    = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   // Beats waiting to be driven, and the TLB results still owed by the block.
   fault_beat_type miss_queue [$];
   tlb_result_type expected_tlb [$];

   // Our own copy of the handler state: directory entries hold slot + 1
   // (zero means no table), page entries hold a valid bit over the frame.
   logic [CSR_DATA_W-1:0] region_reg [8];
   logic [4:0]            dir_table  [DIRECTORY_ENTRIES];
   logic [20:0]           pte_store  [TABLE_SLOTS * TABLE_ENTRIES];
   int unsigned           slots_taken = 0;

   // Directories and pages that most random faults aim at, so that the small
   // table pool is spent on them and lookups hit earlier mappings.
   logic [10:0] hot_dir  [HOT_DIRS];
   logic [8:0]  hot_page [HOT_PAGES];

   int unsigned issued_total   = 0;
   int unsigned accepted_total = 0;
   int unsigned error_count    = 0;
   int unsigned cycle_count    = 0;
   int unsigned mapped_seen    = 0;
   int unsigned frames_seen    = 0;
   int unsigned faults_seen    = 0;
   int unsigned invalid_seen   = 0;
   int unsigned nomem_seen     = 0;

   bit          idle_on  = 1'b1;
   int unsigned req_gap  = 0;
   int unsigned rsp_stall = 0;
   tlb_result_type predicted;
   tlb_result_type oldest;

   two_level_page_fault_handler #(
      .DIRECTORY_ENTRIES(DIRECTORY_ENTRIES),
      .TABLE_ENTRIES    (TABLE_ENTRIES),
      .TABLE_SLOTS      (TABLE_SLOTS),
      .REGION_COUNT     (REGION_COUNT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // An address belongs to a region when it lies at or above the start and
   // less than size bytes past it. The offset is taken in 33 bits, so a region
   // may run right up to the top of the address space.
   function automatic bit address_mapped(input logic [ADDR_W-1:0] addr);
      logic [ADDR_W:0] a33;
      logic [ADDR_W:0] s33;
      logic [ADDR_W:0] z33;
      bit              hit;
      hit = 1'b0;
      a33 = {1'b0, addr};
      for (int k = 0; k < REGION_COUNT; k++) begin
         s33 = {1'b0, region_reg[CSR_START_IDX[k]]};
         z33 = {1'b0, region_reg[CSR_SIZE_IDX[k]]};
         if (a33 >= s33 && (a33 - s33) < z33) hit = 1'b1;
      end
      return hit;
   endfunction

   // Walks our copy of the tables for one fault and updates it the way the
   // handler must: take a table slot for an empty directory entry, record the
   // offered frame for an empty page entry, and change nothing on an error.
   task automatic walk_tables(input logic [FAULT_TYPE_W-1:0] kind,
                              input logic [ADDR_W-1:0] addr,
                              input logic [FRAME_W-1:0] frame,
                              output tlb_result_type res);
      int unsigned      dir;
      int unsigned      pg;
      int unsigned      slot;
      bit               hit;
      bit               no_slot;
      logic [FRAME_W-1:0] frame_out;
      res       = '0;
      hit       = 1'b0;
      no_slot   = 1'b0;
      slot      = 0;
      frame_out = frame;
      res.status = STATUS_OK;
      if (kind == FAULT_READ_ONLY) begin
         res.status = STATUS_FAULT;
      end else if (kind != FAULT_READ && kind != FAULT_WRITE) begin
         res.status = STATUS_INVALID;
      end else if (!address_mapped(addr)) begin
         res.status = STATUS_FAULT;
      end else begin
         dir = addr[31:21] % DIRECTORY_ENTRIES;
         pg  = addr[20:12] % TABLE_ENTRIES;
         if (dir_table[dir] != 0) begin
            slot = dir_table[dir] - 1;
            if (pte_store[slot * TABLE_ENTRIES + pg][20]) begin
               hit       = 1'b1;
               frame_out = pte_store[slot * TABLE_ENTRIES + pg][19:0];
            end
         end else if (slots_taken >= TABLE_SLOTS) begin
            no_slot = 1'b1;
         end else begin
            slot = slots_taken;
            slots_taken++;
            for (int i = 0; i < TABLE_ENTRIES; i++) pte_store[slot * TABLE_ENTRIES + i] = '0;
            dir_table[dir] = 5'(slot + 1);
         end
         if (no_slot) begin
            res.status = STATUS_NOMEM;
         end else begin
            if (!hit) begin
               pte_store[slot * TABLE_ENTRIES + pg] = {1'b1, frame};
               res.frame_taken = 1'b1;
            end
            res.tlb_write = 1'b1;
            res.entry_hi  = {addr[31:12], 12'h000};
            res.entry_lo  = {frame_out, LO_FLAGS};
         end
      end
   endtask

   task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                              input logic [ADDR_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endtask

   // Request driver. It records the prediction for the beat taken at this
   // edge, then waits out or opens an idle burst, or presents the next beat.
   // Each output gets at most one nonblocking assignment per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            walk_tables(req_tuser, req_tdata[31:0], req_tdata[51:32], predicted);
            expected_tlb.push_back(predicted);
            accepted_total++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap > 0) begin
               req_gap    <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (miss_queue.size() != 0) begin
               if (idle_on && $urandom_range(0, 7) == 0) begin
                  req_gap    <= $urandom_range(0, 9);
                  req_tvalid <= 1'b0;
               end else begin
                  req_tdata  <= {{(REQ_TDATA_W - ADDR_W - FRAME_W){1'b0}},
                                 miss_queue[0].frame, miss_queue[0].addr};
                  req_tuser  <= miss_queue[0].kind;
                  req_tvalid <= 1'b1;
                  void'(miss_queue.pop_front());
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Every beat taken is matched against the oldest
   // prediction, field by field; rsp_tready stalls in random bursts when idle_on.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_tlb.size() == 0) begin
               $error("response beat with no outstanding fault, status %0d", rsp_tuser);
               error_count++;
            end else begin
               oldest = expected_tlb.pop_front();
               check_field("status", ADDR_W'(oldest.status), ADDR_W'(rsp_tuser));
               check_field("tlb_write", ADDR_W'(oldest.tlb_write), ADDR_W'(rsp_tdata[0]));
               check_field("tlb_entry_hi", oldest.entry_hi, rsp_tdata[32:1]);
               check_field("tlb_entry_lo", oldest.entry_lo, rsp_tdata[64:33]);
               check_field("frame_taken", ADDR_W'(oldest.frame_taken),
                           ADDR_W'(rsp_tdata[65]));
               case (oldest.status)
                  STATUS_OK:      mapped_seen++;
                  STATUS_FAULT:   faults_seen++;
                  STATUS_INVALID: invalid_seen++;
                  default:        nomem_seen++;
               endcase
               if (oldest.frame_taken) frames_seen++;
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall  <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 11) == 0) begin
            rsp_stall  <= $urandom_range(0, 9);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic queue_miss(input logic [FAULT_TYPE_W-1:0] kind,
                             input logic [ADDR_W-1:0] addr,
                             input logic [FRAME_W-1:0] frame);
      fault_beat_type beat;
      beat.kind  = kind;
      beat.addr  = addr;
      beat.frame = frame;
      miss_queue.push_back(beat);
      issued_total++;
   endtask

   // Configuration writes go out one per edge; our copy follows at once,
   // which is safe because nothing is in flight while they are made.
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_wen    <= 1'b1;
      csr_index  <= idx;
      csr_wdata  <= value;
      region_reg[idx] = value;
   endtask

   task automatic csr_done();
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // Waits until every queued beat has been taken and answered.
   task automatic wait_for_drain();
      do @(posedge clock);
      while (accepted_total != issued_total || expected_tlb.size() != 0);
   endtask

   // Random region settings. Hot regions are windows of up to 4 MiB starting
   // in the hot directories; mixed settings add fully random and extreme ones.
   task automatic program_regions(input int mode);
      logic [CSR_DATA_W-1:0] start;
      logic [CSR_DATA_W-1:0] size;
      int unsigned           pick;
      for (int k = 0; k < REGION_COUNT; k++) begin
         pick  = (mode == REGIONS_HOT) ? $urandom_range(0, 3) : $urandom_range(0, 6);
         start = {hot_dir[$urandom_range(0, HOT_DIRS - 1)], 21'h0}
                 + $urandom_range(0, 21'h1FFFFF);
         size  = $urandom_range(1, 32'h0040_0000);
         case (pick)
            0:       size = '0;
            4:       begin
               start = $urandom;
               size  = $urandom_range(0, 32'h8000_0000);
            end
            5:       begin
               start = 32'hFFFF_FFFF;
               size  = $urandom_range(1, 32'h8000_0000);
            end
            6:       begin
               start = 32'h0000_0000;
               size  = 32'h8000_0000;
            end
            default: ;
         endcase
         csr_write(CSR_START_IDX[k], start);
         csr_write(CSR_SIZE_IDX[k], size);
      end
      csr_done();
   endtask

   // Random faults. Most aim at hot directories and pages so that mappings
   // are built and then hit; some land on region edges and some anywhere.
   task automatic queue_random_misses(input int count);
      int unsigned           r;
      int unsigned           k;
      logic [FAULT_TYPE_W-1:0] kind;
      logic [ADDR_W-1:0]     addr;
      logic [FRAME_W-1:0]    frame;
      logic [CSR_DATA_W-1:0] s;
      logic [CSR_DATA_W-1:0] z;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         if (r < 45)      kind = FAULT_READ;
         else if (r < 85) kind = FAULT_WRITE;
         else if (r < 93) kind = FAULT_READ_ONLY;
         else             kind = FAULT_OTHER;
         r = $urandom_range(0, 99);
         if (r < 60) begin
            addr = {hot_dir[$urandom_range(0, HOT_DIRS - 1)],
                    hot_page[$urandom_range(0, HOT_PAGES - 1)], 12'h0}
                   | $urandom_range(0, 12'hFFF);
         end else if (r < 75) begin
            addr = {hot_dir[$urandom_range(0, HOT_DIRS - 1)], 21'h0}
                   | $urandom_range(0, 21'h1FFFFF);
         end else if (r < 90) begin
            k = $urandom_range(0, REGION_COUNT - 1);
            s = region_reg[CSR_START_IDX[k]];
            z = region_reg[CSR_SIZE_IDX[k]];
            case ($urandom_range(0, 3))
               0:       addr = s;
               1:       addr = s + z - 1;
               2:       addr = s + z;
               default: addr = s - 1;
            endcase
         end else begin
            addr = $urandom;
         end
         r = $urandom_range(0, 99);
         if (r < 5)       frame = '0;
         else if (r < 10) frame = '1;
         else             frame = FRAME_W'($urandom);
         queue_miss(kind, addr, frame);
      end
   endtask

   initial begin
      for (int i = 0; i < 8; i++) region_reg[i] = '0;
      for (int i = 0; i < DIRECTORY_ENTRIES; i++) dir_table[i] = '0;
      for (int i = 0; i < TABLE_SLOTS * TABLE_ENTRIES; i++) pte_store[i] = '0;
      // The directed faults below use these four directories; the rest of
      // the hot set is random.
      hot_dir[0] = 11'h000;
      hot_dir[1] = 11'h7FF;
      hot_dir[2] = 11'h3FF;
      hot_dir[3] = 11'h400;
      for (int i = 4; i < HOT_DIRS; i++) begin
         hot_dir[i] = 11'($urandom_range(0, DIRECTORY_ENTRIES - 1));
      end
      hot_page[0] = 9'h000;
      hot_page[1] = 9'h1FF;
      for (int i = 2; i < HOT_PAGES; i++) hot_page[i] = 9'($urandom_range(0, TABLE_ENTRIES - 1));

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // With every region absent after reset, every good kind is a fault;
      // the read-only kind and the unknown kind are refused before that.
      queue_miss(FAULT_READ, 32'h0000_0000, 20'h00000);
      queue_miss(FAULT_READ_ONLY, 32'h0000_0000, 20'h00000);
      queue_miss(FAULT_OTHER, 32'hFFFF_FFFF, 20'hFFFFF);
      wait_for_drain();

      // Cover the whole space: the lower half at its largest size, the upper
      // half ending exactly at the top, the single top byte, and region
      // three written but absent.
      csr_write(CSR_REGION_START_0, 32'h0000_0000);
      csr_write(CSR_REGION_SIZE_0, 32'h8000_0000);
      csr_write(CSR_REGION_START_1, 32'h8000_0000);
      csr_write(CSR_REGION_SIZE_1, 32'h8000_0000);
      csr_write(CSR_REGION_START_2, 32'hFFFF_FFFF);
      csr_write(CSR_REGION_SIZE_2, 32'h0000_0001);
      csr_write(CSR_REGION_START_3, 32'h1234_5678);
      csr_write(CSR_REGION_SIZE_3, 32'h0000_0000);
      csr_done();
      queue_miss(FAULT_READ, 32'h0000_0000, 20'h00000);   // new table, lowest page
      queue_miss(FAULT_WRITE, 32'h0000_0FFF, 20'hFFFFF);  // hit keeps the old frame
      queue_miss(FAULT_WRITE, 32'hFFFF_FFFF, 20'hFFFFF);  // new table, highest page
      queue_miss(FAULT_READ, 32'hFFFF_F000, 20'h12345);   // hit at the top
      queue_miss(FAULT_READ, 32'h001F_F000, 20'hABCDE);   // new page, existing table
      queue_miss(FAULT_READ_ONLY, 32'h001F_F000, 20'h11111);
      queue_miss(FAULT_OTHER, 32'h001F_F000, 20'h22222);
      queue_miss(FAULT_WRITE, 32'h7FFF_FFFF, 20'h5A5A5);  // last byte of region zero
      queue_miss(FAULT_READ, 32'h8000_0000, 20'h00001);   // first byte of region one
      wait_for_drain();

      // Only one page of directory zero is open now, through region three.
      csr_write(CSR_REGION_SIZE_0, 32'h0000_0000);
      csr_write(CSR_REGION_SIZE_2, 32'h0000_0000);
      csr_write(CSR_REGION_START_3, 32'h0000_1000);
      csr_write(CSR_REGION_SIZE_3, 32'h0000_1000);
      csr_done();
      queue_miss(FAULT_READ, 32'h0000_0000, 20'h33333);   // mapped page, now outside
      queue_miss(FAULT_READ, 32'h0000_1000, 20'h00007);   // first byte of region three
      queue_miss(FAULT_WRITE, 32'h0000_1FFF, 20'h44444);  // last byte, hit
      queue_miss(FAULT_READ, 32'h0000_2000, 20'h55555);   // one past the end
      queue_miss(FAULT_READ, 32'h0000_0FFF, 20'h66666);   // one below the start
      queue_miss(FAULT_WRITE, 32'hFFFF_FFFF, 20'h77777);  // still mapped via region one
      wait_for_drain();

      // Random phases. The table pool runs dry somewhere in here, after
      // which faults in directories without a table report out of memory.
      program_regions(REGIONS_HOT);
      queue_random_misses(220);
      wait_for_drain();

      idle_on = 1'b0;
      program_regions(REGIONS_MIXED);
      queue_random_misses(200);
      wait_for_drain();

      idle_on = 1'b1;
      program_regions(REGIONS_MIXED);
      queue_random_misses(220);
      wait_for_drain();

      // Final phase runs without idling: regions zero and one absent, the
      // space covered by regions two and three alone.
      idle_on = 1'b0;
      csr_write(CSR_REGION_START_0, 32'hFFFF_FFFF);
      csr_write(CSR_REGION_SIZE_0, 32'h0000_0000);
      csr_write(CSR_REGION_START_1, 32'h0000_0000);
      csr_write(CSR_REGION_SIZE_1, 32'h0000_0000);
      csr_write(CSR_REGION_START_2, 32'h0000_0000);
      csr_write(CSR_REGION_SIZE_2, 32'h8000_0000);
      csr_write(CSR_REGION_START_3, 32'h8000_0000);
      csr_write(CSR_REGION_SIZE_3, 32'h8000_0000);
      csr_done();
      queue_random_misses(210);
      wait_for_drain();

      // Give any stray response time to show up before the verdict.
      repeat (16) @(posedge clock);
      if (expected_tlb.size() != 0) begin
         $error("%0d TLB results never arrived", expected_tlb.size());
         error_count++;
      end

      $display("Ran %0d fault beats: %0d mapped, %0d frames recorded, %0d faults,",
               accepted_total, mapped_seen, frames_seen, faults_seen);
      $display("  %0d invalid kinds, %0d out of tables; %0d of %0d tables taken.",
               invalid_seen, nomem_seen, slots_taken, TABLE_SLOTS);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
